// ===== rtl/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block except wsd_checker.
package wsd_pkg;

    localparam int LEN_BITS     = 64;   // payload length counter width (16..64)
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam logic [7:0] HDR_FIN_BIT   = 8'h80;
    localparam logic [7:0] HDR_OPC_MASK  = 8'h0F;
    localparam logic [7:0] HDR_LEN_MASK  = 8'h7F;
    localparam logic [7:0] HDR_MASK_BIT  = 8'h80;
    localparam logic [6:0] LEN_EXT16     = 7'd126;
    localparam logic [6:0] LEN_EXT64     = 7'd127;
    localparam logic [3:0] OPC_BINARY    = 4'h2;
    localparam logic [3:0] EXT16_BYTES   = 4'd2;
    localparam logic [3:0] EXT64_BYTES   = 4'd8;
    localparam logic [2:0] MASK_KEY_BYTES = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       last;
    } t_beat;

endpackage

// ===== rtl/websocket_frame_deframer_core.sv =====
// WebSocket client-to-server frame deframer, one byte per beat.
// Slave stream: s_tdata carries the frame byte stream (header, extended
// length, mask key, payload). Master stream: m_tdata is the unmasked payload
// byte of a binary frame, m_tuser the frame's FIN bit, m_tlast marks the last
// payload byte of the frame. Header bytes and all non-binary frames produce
// no output beat; zero-length frames produce nothing.
// A payload byte accepted on the slave side is written into the queue, then
// loaded into the output register, which presents it on the master side.
// Throughput: one byte per cycle while the queue is not full; the parser updates
// its header state and unmasks in a single cycle per byte.
// A four-entry queue separates the parser from the output register, so
// while the receiver stalls the slave side keeps accepting until the queue
// fills; s_tready then drops until the receiver takes a beat.
// Reset (i_rst_n low, synchronous) returns the parser to expect a new frame
// header and empties the queue and output register.
// Depends on wsd_pkg, wsd_parser, wsd_fifo and wsd_out.
module websocket_frame_deframer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic       m_tuser,   // [0] fin_flag
    output logic       m_tlast
);
    import wsd_pkg::*;

    logic  accept, push, pop, q_empty, q_full;
    t_beat parsed, head, out_beat;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    wsd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_byte  (s_tdata),
        .o_push  (push),
        .o_beat  (parsed)
    );

    wsd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (parsed),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_head  (head)
    );

    wsd_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_head   (head),
        .o_pop    (pop),
        .i_tready (m_tready),
        .o_tvalid (m_tvalid),
        .o_beat   (out_beat)
    );

    assign m_tdata = out_beat.data;
    assign m_tuser = out_beat.fin;
    assign m_tlast = out_beat.last;

endmodule

// ===== rtl/wsd_parser.sv =====
// Front end: walks the frame header per accepted byte, unmasks payload bytes
// of binary frames and pushes them into the queue. Depends on wsd_pkg.
module wsd_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    output logic           o_push,
    output wsd_pkg::t_beat o_beat
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    t_phase              r_phase,     n_phase;
    logic [3:0]          r_ext_left,  n_ext_left;
    logic [LEN_BITS-1:0] r_remain,    n_remain;
    logic [31:0]         r_key,       n_key;
    logic [2:0]          r_mask_left, n_mask_left;
    logic                r_masked,    n_masked;
    logic [1:0]          r_idx,       n_idx;
    logic                r_fin,       n_fin;
    logic                r_kept,      n_kept;
    logic [7:0]          key_byte;
    logic [6:0]          len7;

    always_comb begin
        case (r_idx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    assign len7 = i_byte[6:0] & HDR_LEN_MASK[6:0];

    always_comb begin
        n_phase     = r_phase;
        n_ext_left  = r_ext_left;
        n_remain    = r_remain;
        n_key       = r_key;
        n_mask_left = r_mask_left;
        n_masked    = r_masked;
        n_idx       = r_idx;
        n_fin       = r_fin;
        n_kept      = r_kept;
        o_push      = 1'b0;
        o_beat      = '{data: i_byte ^ key_byte, fin: r_fin, last: 1'b0};
        if (i_valid) begin
            case (r_phase)
                PH_HDR1: begin
                    n_masked = (i_byte & HDR_MASK_BIT) != 8'h00;
                    if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                        n_ext_left = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        n_remain   = '0;
                        n_phase    = PH_EXT;
                    end else begin
                        n_remain = LEN_BITS'(len7);
                    end
                end
                PH_EXT: begin
                    n_remain   = {r_remain[LEN_BITS-9:0], i_byte};
                    n_ext_left = r_ext_left - 4'd1;
                end
                PH_MASK: begin
                    n_key       = {r_key[23:0], i_byte};
                    n_mask_left = r_mask_left - 3'd1;
                end
                PH_DATA: begin
                    n_remain = r_remain - LEN_BITS'(1);
                    n_idx    = r_idx + 2'd1;
                    if (n_remain == '0) begin
                        n_phase = PH_HDR0;
                    end
                    o_push      = r_kept;
                    o_beat.last = (n_remain == '0);
                end
                default: begin
                    // unused codes act as the first header byte
                    n_fin   = (i_byte & HDR_FIN_BIT) != 8'h00;
                    n_kept  = (i_byte & HDR_OPC_MASK) == {4'h0, OPC_BINARY};
                    n_phase = PH_HDR1;
                end
            endcase

            // length complete: load mask key, or go straight to payload (next header if empty)
            if ((r_phase == PH_HDR1 && !(len7 == LEN_EXT16 || len7 == LEN_EXT64)) ||
                (r_phase == PH_EXT && n_ext_left == 4'd0)) begin
                n_key = '0;
                if (n_masked) begin
                    n_mask_left = MASK_KEY_BYTES;
                    n_phase     = PH_MASK;
                end else begin
                    n_mask_left = 3'd0;
                    n_idx       = 2'd0;
                    n_phase     = (n_remain == '0) ? PH_HDR0 : PH_DATA;
                end
            end
            if (r_phase == PH_MASK && n_mask_left == 3'd0) begin
                n_idx   = 2'd0;
                n_phase = (n_remain == '0) ? PH_HDR0 : PH_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_ext_left  <= '0;
            r_remain    <= '0;
            r_key       <= '0;
            r_mask_left <= '0;
            r_masked    <= 1'b0;
            r_idx       <= '0;
            r_fin       <= 1'b0;
            r_kept      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_ext_left  <= n_ext_left;
            r_remain    <= n_remain;
            r_key       <= n_key;
            r_mask_left <= n_mask_left;
            r_masked    <= n_masked;
            r_idx       <= n_idx;
            r_fin       <= n_fin;
            r_kept      <= n_kept;
        end
    end

endmodule

// ===== rtl/wsd_fifo.sv =====
// Short queue of payload beats between the parser and the output stage.
// Depends on wsd_pkg for the beat type and depth.
module wsd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wsd_pkg::t_beat i_beat,
    input  logic           i_pop,
    output logic           o_empty,
    output logic           o_full,
    output wsd_pkg::t_beat o_head
);
    import wsd_pkg::*;

    t_beat                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]     r_count;
    logic                 do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (FIFO_AW+1)'(1);
                2'b01:   r_count <= r_count - (FIFO_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/wsd_out.sv =====
// Back end: output register that drains the queue onto the master stream.
// Depends on wsd_pkg for the beat type.
module wsd_out (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  wsd_pkg::t_beat i_head,
    output logic           o_pop,
    input  logic           i_tready,
    output logic           o_tvalid,
    output wsd_pkg::t_beat o_beat
);
    import wsd_pkg::*;

    logic  r_valid;
    t_beat r_beat;

    // load whenever the queue holds a beat and the register is free or being drained this cycle
    assign o_pop    = !i_empty && (!r_valid || i_tready);
    assign o_tvalid = r_valid;
    assign o_beat   = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_beat <= i_head;
        end
    end

endmodule

// ===== rtl/wsd_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
// Depends only on the top-level port list.
module wsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // nothing is presented in the first cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

    // the queue can only fill up behind a waiting output beat
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no output pending");

    // a beat taken at the output frees room, so input stalls cannot persist
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready && m_tready |=> s_tready)
        else $error("input still stalled after output beat taken");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (.*);
